FILE: rtl/mtlp_pkg.sv
// Types, widths and constants shared by the meter telegram line parser.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package mtlp_pkg;

    localparam int WHOLE_W  = 48;
    localparam int FRAC_W   = 32;
    localparam int COUNT_W  = 16;
    localparam int POWER_W  = 32;
    localparam int GAS_W    = 48;
    localparam int SCALE_W  = 10;
    localparam int PROD_W   = 58;
    localparam int FPROD_W  = FRAC_W + SCALE_W;
    localparam int SUM_W    = PROD_W + 1;

    localparam logic [WHOLE_W-1:0] WHOLE_MAX = {WHOLE_W{1'b1}};
    localparam logic [FRAC_W-1:0]  FRAC_MAX  = {FRAC_W{1'b1}};
    localparam logic [POWER_W-1:0] POWER_MAX = {POWER_W{1'b1}};
    localparam logic [GAS_W-1:0]   GAS_MAX   = {GAS_W{1'b1}};

    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_DOT  = 8'h2E;

    localparam logic KIND_POWER = 1'b0;
    localparam logic KIND_GAS   = 1'b1;

    localparam logic [3:0] POWER_TAG_LEN = 4'd10;
    localparam logic [3:0] GAS_TAG_LEN   = 4'd11;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // One finished line, handed from the parser to the arithmetic back end
    typedef struct packed {
        logic               kind;
        logic               version;
        logic [1:0]         digits;
        logic [FRAC_W-1:0]  frac;
        logic [WHOLE_W-1:0] whole;
    } line_rec_t;

    // Character of the line prefix at a given offset ("1-0:1.7.0(" or "0-1:24.2.1(")
    function automatic logic [7:0] tag_char(input logic kind, input logic [3:0] offset);
        logic [7:0] c;
        c = 8'h00;
        if (kind == KIND_GAS) begin
            case (offset)
                4'd0:    c = "0";
                4'd1:    c = "-";
                4'd2:    c = "1";
                4'd3:    c = ":";
                4'd4:    c = "2";
                4'd5:    c = "4";
                4'd6:    c = ".";
                4'd7:    c = "2";
                4'd8:    c = ".";
                4'd9:    c = "1";
                4'd10:   c = "(";
                default: c = 8'h00;
            endcase
        end else begin
            case (offset)
                4'd0:    c = "1";
                4'd1:    c = "-";
                4'd2:    c = "0";
                4'd3:    c = ":";
                4'd4:    c = "1";
                4'd5:    c = ".";
                4'd6:    c = "7";
                4'd7:    c = ".";
                4'd8:    c = "0";
                4'd9:    c = "(";
                default: c = 8'h00;
            endcase
        end
        return c;
    endfunction

    // Weight of the fraction: power scales by ten in the older telegram,
    // gas pads missing thousandths digits
    function automatic logic [SCALE_W-1:0] frac_scale(input logic kind,
                                                      input logic version,
                                                      input logic [1:0] digits);
        logic [SCALE_W-1:0] s;
        s = 10'd1;
        if (kind == KIND_GAS) begin
            case (digits)
                2'd0:    s = 10'd1000;
                2'd1:    s = 10'd100;
                2'd2:    s = 10'd10;
                default: s = 10'd1;
            endcase
        end else begin
            s = version ? 10'd1 : 10'd10;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/mtlp_front.sv
// Byte-level front end: drops carriage returns, matches the line prefix and
// accumulates the number digits. Depends on mtlp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mtlp_front #(
    parameter int LINE_LEN = 80
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                byte_valid,
    input  wire logic [7:0]          rx_byte,
    input  wire logic                cfg_write,
    input  wire logic                cfg_data,
    output logic                     rec_push,
    output mtlp_pkg::line_rec_t      rec
);
    import mtlp_pkg::*;

    localparam int POS_W = $clog2(LINE_LEN);

    typedef enum logic [9:0] {
        PH_PREFIX  = 10'b0000000001,
        PH_P_INT0  = 10'b0000000010,
        PH_P_INT   = 10'b0000000100,
        PH_P_FRAC0 = 10'b0000001000,
        PH_P_FRAC  = 10'b0000010000,
        PH_G_INT0  = 10'b0000100000,
        PH_G_INT   = 10'b0001000000,
        PH_G_DOT0  = 10'b0010000000,
        PH_G_FRAC  = 10'b0100000000,
        PH_DONE    = 10'b1000000000
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [3:0]         offset_reg, offset_next;
    logic               kind_reg, kind_next;
    logic               dead_reg, dead_next;
    logic [WHOLE_W-1:0] whole_reg, whole_next;
    logic [FRAC_W-1:0]  frac_reg, frac_next;
    logic [1:0]         digits_reg, digits_next;
    logic               version_reg;

    logic               is_digit;
    logic [3:0]         digit;
    logic               kind_cur;
    logic [3:0]         tag_len;
    logic               line_ok;
    logic               wrap;
    logic [WHOLE_W-1:0] whole_acc;
    logic [FRAC_W-1:0]  frac_acc;
    logic [FRAC_W-1:0]  gas_frac_acc;

    // Saturating v*10+d
    function automatic logic [WHOLE_W-1:0] acc10_whole(input logic [WHOLE_W-1:0] v,
                                                       input logic [3:0] d);
        logic [WHOLE_W+3:0] s;
        s = (WHOLE_W+4)'({v, 3'b000}) + (WHOLE_W+4)'({v, 1'b0}) + (WHOLE_W+4)'(d);
        return (s > (WHOLE_W+4)'(WHOLE_MAX)) ? WHOLE_MAX : s[WHOLE_W-1:0];
    endfunction

    function automatic logic [FRAC_W-1:0] acc10_frac(input logic [FRAC_W-1:0] v,
                                                     input logic [3:0] d);
        logic [FRAC_W+3:0] s;
        s = (FRAC_W+4)'({v, 3'b000}) + (FRAC_W+4)'({v, 1'b0}) + (FRAC_W+4)'(d);
        return (s > (FRAC_W+4)'(FRAC_MAX)) ? FRAC_MAX : s[FRAC_W-1:0];
    endfunction

    assign is_digit     = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
    assign digit        = is_digit ? rx_byte[3:0] : 4'd0;
    assign kind_cur     = (offset_reg == 4'd0) ? (rx_byte == CH_ZERO) : kind_reg;
    assign tag_len      = kind_cur ? GAS_TAG_LEN : POWER_TAG_LEN;
    assign whole_acc    = acc10_whole(whole_reg, digit);
    assign frac_acc     = acc10_frac(frac_reg, digit);
    assign gas_frac_acc = {frac_reg[FRAC_W-4:0], 3'b000} + {frac_reg[FRAC_W-2:0], 1'b0}
                          + FRAC_W'(digit);
    assign wrap         = ((POS_W+1)'(pos_reg) + (POS_W+1)'(1)) == (POS_W+1)'(LINE_LEN);

    always_comb
    begin
        if (kind_reg == KIND_POWER)
            line_ok = !dead_reg && (phase_reg == PH_P_FRAC || phase_reg == PH_DONE);
        else
            line_ok = !dead_reg && (phase_reg == PH_G_INT || phase_reg == PH_G_FRAC
                                    || phase_reg == PH_DONE);
    end

    always_comb
    begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        offset_next = offset_reg;
        kind_next   = kind_reg;
        dead_next   = dead_reg;
        whole_next  = whole_reg;
        frac_next   = frac_reg;
        digits_next = digits_reg;
        rec_push    = 1'b0;

        if (byte_valid && rx_byte != CH_CR) begin
            if (rx_byte == CH_LF) begin
                rec_push = line_ok;
            end else if (!dead_reg && phase_reg != PH_DONE) begin
                case (phase_reg)
                    PH_PREFIX:
                    begin
                        kind_next = kind_cur;
                        if (offset_reg >= tag_len || tag_char(kind_cur, offset_reg) != rx_byte)
                            dead_next = 1'b1;
                        else begin
                            offset_next = offset_reg + 4'd1;
                            if (offset_reg + 4'd1 == tag_len)
                                phase_next = kind_cur ? PH_G_INT0 : PH_P_INT0;
                        end
                    end
                    PH_P_INT0, PH_G_INT0:
                    begin
                        if (is_digit) begin
                            whole_next = whole_acc;
                            phase_next = (phase_reg == PH_P_INT0) ? PH_P_INT : PH_G_INT;
                        end else if (rx_byte == CH_DOT && phase_reg == PH_G_INT0)
                            phase_next = PH_G_DOT0;
                        else
                            dead_next = 1'b1;
                    end
                    PH_P_INT:
                    begin
                        if (is_digit)
                            whole_next = whole_acc;
                        else if (rx_byte == CH_DOT)
                            phase_next = PH_P_FRAC0;
                        else
                            dead_next = 1'b1;
                    end
                    PH_P_FRAC0, PH_P_FRAC:
                    begin
                        if (is_digit) begin
                            frac_next  = frac_acc;
                            phase_next = PH_P_FRAC;
                        end else if (phase_reg == PH_P_FRAC)
                            phase_next = PH_DONE;
                        else
                            dead_next = 1'b1;
                    end
                    PH_G_INT:
                    begin
                        if (is_digit)
                            whole_next = whole_acc;
                        else if (rx_byte == CH_DOT)
                            phase_next = PH_G_FRAC;
                        else
                            phase_next = PH_DONE;
                    end
                    PH_G_DOT0, PH_G_FRAC:
                    begin
                        if (is_digit) begin
                            if (digits_reg != 2'd3) begin
                                frac_next   = gas_frac_acc;
                                digits_next = digits_reg + 2'd1;
                            end
                            phase_next = PH_G_FRAC;
                        end else if (phase_reg == PH_G_FRAC)
                            phase_next = PH_DONE;
                        else
                            dead_next = 1'b1;
                    end
                    default:
                    begin
                        dead_next = 1'b1;
                    end
                endcase
            end

            // Restart the line on a line feed or when it fills up
            if (rx_byte == CH_LF || wrap) begin
                pos_next    = '0;
                phase_next  = PH_PREFIX;
                offset_next = 4'd0;
                kind_next   = KIND_POWER;
                dead_next   = 1'b0;
                whole_next  = '0;
                frac_next   = '0;
                digits_next = 2'd0;
            end else begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg   <= PH_PREFIX;
            pos_reg     <= '0;
            offset_reg  <= 4'd0;
            kind_reg    <= KIND_POWER;
            dead_reg    <= 1'b0;
            whole_reg   <= '0;
            frac_reg    <= '0;
            digits_reg  <= 2'd0;
            version_reg <= 1'b1;
        end else begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            offset_reg <= offset_next;
            kind_reg   <= kind_next;
            dead_reg   <= dead_next;
            whole_reg  <= whole_next;
            frac_reg   <= frac_next;
            digits_reg <= digits_next;
            if (cfg_write)
                version_reg <= cfg_data;
        end
    end

    assign rec.kind    = kind_reg;
    assign rec.version = version_reg;
    assign rec.digits  = digits_reg;
    assign rec.frac    = frac_reg;
    assign rec.whole   = whole_reg;

endmodule

`default_nettype wire

FILE: rtl/mtlp_queue.sv
// Short queue of finished lines between the parser and the arithmetic.
// Depends on mtlp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mtlp_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                wr_en,
    input  wire mtlp_pkg::line_rec_t wr_rec,
    input  wire logic                rd_en,
    output logic                     rd_valid,
    output mtlp_pkg::line_rec_t      rd_rec,
    output logic                     q_full
);
    import mtlp_pkg::*;

    line_rec_t         entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign rd_valid = count_reg != '0;
    assign q_full   = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign rd_rec   = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            entry_reg[wr_ptr_reg] <= wr_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (rd_en)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            if (wr_en && !rd_en)
                count_reg <= count_reg + QCNT_W'(1);
            else if (rd_en && !wr_en)
                count_reg <= count_reg - QCNT_W'(1);
        end
    end

endmodule

`default_nettype wire

FILE: rtl/mtlp_back.sv
// Arithmetic back end: scales the parsed number, saturates, counts power
// readings and holds the result word. Depends on mtlp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mtlp_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                q_valid,
    input  wire mtlp_pkg::line_rec_t q_rec,
    output logic                     q_take,
    output logic                     out_valid,
    input  wire logic                out_take,
    output logic                     reading_kind,
    output logic [15:0]              reading_count,
    output logic [31:0]              power_watts,
    output logic [47:0]              gas_thousandths
);
    import mtlp_pkg::*;

    logic               s1_valid_reg;
    logic               s1_kind_reg;
    logic [COUNT_W-1:0] s1_count_reg;
    logic [PROD_W-1:0]  s1_whole_reg;
    logic [FPROD_W-1:0] s1_frac_reg;

    logic               out_valid_reg;
    logic               out_kind_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic [POWER_W-1:0] out_power_reg;
    logic [GAS_W-1:0]   out_gas_reg;

    logic [COUNT_W-1:0] power_count_reg, power_count_next;
    logic               out_adv;
    logic               s1_load;
    logic [PROD_W-1:0]  whole_k;
    logic [SUM_W-1:0]   sum;

    assign out_adv = !out_valid_reg || out_take;
    assign s1_load = q_valid && (!s1_valid_reg || out_adv);
    assign q_take  = s1_load;

    // whole * 1000 = whole*1024 - whole*16 - whole*8
    assign whole_k = {q_rec.whole, 10'b0} - PROD_W'({q_rec.whole, 4'b0})
                     - PROD_W'({q_rec.whole, 3'b0});

    assign power_count_next = (q_rec.kind == KIND_POWER) ? power_count_reg + COUNT_W'(1)
                                                         : power_count_reg;

    assign sum = SUM_W'(s1_whole_reg) + SUM_W'(s1_frac_reg);

    always_ff @(posedge clk)
    begin
        if (s1_load) begin
            s1_kind_reg  <= q_rec.kind;
            s1_count_reg <= power_count_next;
            s1_whole_reg <= whole_k;
            s1_frac_reg  <= q_rec.frac * frac_scale(q_rec.kind, q_rec.version, q_rec.digits);
        end
        if (s1_valid_reg && out_adv) begin
            out_kind_reg  <= s1_kind_reg;
            out_count_reg <= s1_count_reg;
            if (s1_kind_reg == KIND_POWER) begin
                out_power_reg <= (sum > SUM_W'(POWER_MAX)) ? POWER_MAX : sum[POWER_W-1:0];
                out_gas_reg   <= '0;
            end else begin
                out_power_reg <= '0;
                out_gas_reg   <= (sum > SUM_W'(GAS_MAX)) ? GAS_MAX : sum[GAS_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            power_count_reg <= '0;
        end else begin
            if (s1_load)
                power_count_reg <= power_count_next;
            if (s1_load)
                s1_valid_reg <= 1'b1;
            else if (out_adv)
                s1_valid_reg <= 1'b0;
            if (out_adv)
                out_valid_reg <= s1_valid_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign reading_kind    = out_kind_reg;
    assign reading_count   = out_count_reg;
    assign power_watts     = out_power_reg;
    assign gas_thousandths = out_gas_reg;

endmodule

`default_nettype wire

FILE: rtl/meter_telegram_line_parser.sv
// Top level of the meter telegram line parser: parser front end, line queue
// and arithmetic back end. Depends on mtlp_pkg, mtlp_front, mtlp_queue, mtlp_back.
//
// Usage:
//   Input channel: drive rx_byte and raise push; a byte is taken at each rising
//   edge with push high and full low. One byte per cycle is sustained; full
//   rises only when four finished readings wait in the line queue.
//   Result channel: while empty is low the oldest reading is on reading_kind,
//   reading_count, power_watts and gas_thousandths; pop takes it.
//   A reading comes only from the line feed that closes a matching power or
//   gas line; other bytes and non-matching lines give no word.
//   Path: a reading passes the queue write, the scaling stage and the output
//   register, and waits while the result side is stalled. Throughput: one byte
//   per cycle in while full is low, one word per cycle out while pop stays high.
//   Stall: while pop is held low, words back up through the scaling stage and
//   the line queue; bytes keep flowing until the queue fills.
//   Configuration: cfg_write loads cfg_data into protocol_version; it is read
//   when a line feed is taken.
//   Reset: clears the line state, the power count and all queued words, and
//   sets protocol_version to 1.
`timescale 1ns / 1ps
`default_nettype none

module meter_telegram_line_parser #(
    parameter int LINE_LEN = 80
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  rx_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic             reading_kind,
    output logic [15:0]      reading_count,
    output logic [31:0]      power_watts,
    output logic [47:0]      gas_thousandths,
    input  wire logic        cfg_write,
    input  wire logic        cfg_data
);
    import mtlp_pkg::*;

    logic      byte_taken;
    logic      rec_push;
    line_rec_t front_rec;
    logic      q_valid;
    line_rec_t q_rec;
    logic      q_take;
    logic      q_full;
    logic      out_valid;
    logic      out_take;

    // Hold input while the line queue is full
    assign full       = q_full;
    assign byte_taken = push && !q_full;
    assign empty      = !out_valid;
    assign out_take   = pop && out_valid;

    mtlp_front #(
        .LINE_LEN (LINE_LEN)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_taken),
        .rx_byte    (rx_byte),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data),
        .rec_push   (rec_push),
        .rec        (front_rec)
    );

    mtlp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (rec_push),
        .wr_rec   (front_rec),
        .rd_en    (q_take),
        .rd_valid (q_valid),
        .rd_rec   (q_rec),
        .q_full   (q_full)
    );

    mtlp_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_valid),
        .q_rec           (q_rec),
        .q_take          (q_take),
        .out_valid       (out_valid),
        .out_take        (out_take),
        .reading_kind    (reading_kind),
        .reading_count   (reading_count),
        .power_watts     (power_watts),
        .gas_thousandths (gas_thousandths)
    );

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Testbench for meter_telegram_line_parser: streams telegram bytes through the
// push/full side and checks every reading word against a cycle-free predictor.
// Depends on mtlp_pkg and the RTL of the block; reads no files.
`timescale 1ns / 1ps

module tb;

    import mtlp_pkg::*;

    localparam int LINE_LEN       = 80;
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_LIMIT    = 4000;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int RANDOM_BYTES   = 150;
    localparam int LIMIT_NS       = 2000000;

    localparam logic [7:0] CH_NUL = 8'h00;

    // Line prefixes, first character in the top byte
    localparam logic [8*10-1:0] POWER_TAG = "1-0:1.7.0(";
    localparam logic [8*11-1:0] GAS_TAG   = "0-1:24.2.1(";

    typedef enum logic [9:0] {
        PS_TAG       = 10'b0000000001,
        PS_PWR_INT0  = 10'b0000000010,
        PS_PWR_INT   = 10'b0000000100,
        PS_PWR_FRAC0 = 10'b0000001000,
        PS_PWR_FRAC  = 10'b0000010000,
        PS_GAS_INT0  = 10'b0000100000,
        PS_GAS_INT   = 10'b0001000000,
        PS_GAS_DOT   = 10'b0010000000,
        PS_GAS_FRAC  = 10'b0100000000,
        PS_DONE      = 10'b1000000000
    } parse_state_t;

    // One reading word as it leaves the block
    typedef struct {
        logic        kind;
        logic [15:0] count;
        logic [31:0] watts;
        logic [47:0] gas;
    } reading_t;

    // ------------------------------------------------------------------
    // DUT signals; every input has a known value from time zero
    // ------------------------------------------------------------------
    logic        clk;
    logic        rst_n     = 1'b0;
    logic        push      = 1'b0;
    logic [7:0]  rx_byte   = 8'h00;
    logic        pop       = 1'b0;
    logic        cfg_write = 1'b0;
    logic        cfg_data  = 1'b0;
    logic        full;
    logic        empty;
    logic        reading_kind;
    logic [15:0] reading_count;
    logic [31:0] power_watts;
    logic [47:0] gas_thousandths;

    meter_telegram_line_parser #(
        .LINE_LEN(LINE_LEN)
    ) u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .rx_byte        (rx_byte),
        .empty          (empty),
        .pop            (pop),
        .reading_kind   (reading_kind),
        .reading_count  (reading_count),
        .power_watts    (power_watts),
        .gas_thousandths(gas_thousandths),
        .cfg_write      (cfg_write),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop in case a word never shows up or the input never frees
    initial
    begin
        #(LIMIT_NS);
        $display("tb: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor state: own copy of the line parser and the configuration
    // ------------------------------------------------------------------
    logic         meter_ver;
    logic [6:0]   line_pos;
    parse_state_t pstate;
    logic [3:0]   tag_off;
    logic         line_gas;
    logic         line_bad;
    logic [47:0]  whole_acc;
    logic [31:0]  frac_acc;
    logic [1:0]   frac_cnt;
    logic [15:0]  power_readings;

    reading_t expected_readings[$];   // words owed by the block, oldest first
    int       fail_count   = 0;

    // Stimulus state
    logic [7:0] line_bytes[$];        // line under construction
    int         bytes_sent = 0;
    int         burst_left = 0;
    bit         steady     = 1'b0;    // sender offers back to back when set
    bit         hold_req   = 1'b0;    // asks the receiver for one long hold-off

    function automatic logic [7:0] tag_at(input logic kind, input logic [3:0] off);
        if (kind == KIND_GAS)
            return GAS_TAG[8*(10-off) +: 8];
        return POWER_TAG[8*(9-off) +: 8];
    endfunction

    // Multiply-by-ten accumulate that sticks at the given ceiling
    function automatic logic [63:0] shift_in_digit(input logic [63:0] v,
                                                   input logic [63:0] d,
                                                   input logic [63:0] top);
        if (v > (top - d) / 64'd10)
            return top;
        return v * 64'd10 + d;
    endfunction

    function automatic void clear_line();
        pstate    = PS_TAG;
        tag_off   = 4'd0;
        line_gas  = KIND_POWER;
        line_bad  = 1'b0;
        whole_acc = '0;
        frac_acc  = '0;
        frac_cnt  = 2'd0;
    endfunction

    // Advance the parse by one character that is neither CR nor LF
    function automatic void advance_parser(input logic [7:0] b);
        logic        is_dig;
        logic [63:0] d;
        logic [63:0] acc;
        logic [3:0]  tag_len;
        is_dig = (b >= CH_ZERO) && (b <= CH_NINE);
        d      = is_dig ? {56'd0, b - CH_ZERO} : 64'd0;
        if (line_bad || pstate == PS_DONE)
            return;
        case (pstate)
            PS_TAG:
            begin
                // The first character picks which prefix the line must carry
                if (tag_off == 4'd0)
                    line_gas = (b == CH_ZERO) ? KIND_GAS : KIND_POWER;
                tag_len = (line_gas == KIND_GAS) ? GAS_TAG_LEN : POWER_TAG_LEN;
                if (tag_off >= tag_len || b != tag_at(line_gas, tag_off))
                begin
                    line_bad = 1'b1;
                    return;
                end
                tag_off = tag_off + 4'd1;
                if (tag_off == tag_len)
                    pstate = (line_gas == KIND_GAS) ? PS_GAS_INT0 : PS_PWR_INT0;
            end
            PS_PWR_INT0, PS_GAS_INT0:
            begin
                if (is_dig)
                begin
                    acc       = shift_in_digit({16'd0, whole_acc}, d, {16'd0, WHOLE_MAX});
                    whole_acc = acc[47:0];
                    pstate    = (pstate == PS_PWR_INT0) ? PS_PWR_INT : PS_GAS_INT;
                end
                else if (b == CH_DOT && pstate == PS_GAS_INT0)
                    pstate = PS_GAS_DOT;
                else
                    line_bad = 1'b1;
            end
            PS_PWR_INT:
            begin
                if (is_dig)
                begin
                    acc       = shift_in_digit({16'd0, whole_acc}, d, {16'd0, WHOLE_MAX});
                    whole_acc = acc[47:0];
                end
                else if (b == CH_DOT)
                    pstate = PS_PWR_FRAC0;
                else
                    line_bad = 1'b1;
            end
            PS_PWR_FRAC0, PS_PWR_FRAC:
            begin
                if (is_dig)
                begin
                    acc      = shift_in_digit({32'd0, frac_acc}, d, {32'd0, FRAC_MAX});
                    frac_acc = acc[31:0];
                    pstate   = PS_PWR_FRAC;
                end
                else if (pstate == PS_PWR_FRAC)
                    pstate = PS_DONE;
                else
                    line_bad = 1'b1;
            end
            PS_GAS_INT:
            begin
                if (is_dig)
                begin
                    acc       = shift_in_digit({16'd0, whole_acc}, d, {16'd0, WHOLE_MAX});
                    whole_acc = acc[47:0];
                end
                else if (b == CH_DOT)
                    pstate = PS_GAS_FRAC;
                else
                    pstate = PS_DONE;
            end
            PS_GAS_DOT, PS_GAS_FRAC:
            begin
                // Keep three fraction digits, truncate the rest
                if (is_dig)
                begin
                    if (frac_cnt < 2'd3)
                    begin
                        frac_acc = frac_acc * 32'd10 + d[31:0];
                        frac_cnt = frac_cnt + 2'd1;
                    end
                    pstate = PS_GAS_FRAC;
                end
                else if (pstate == PS_GAS_FRAC)
                    pstate = PS_DONE;
                else
                    line_bad = 1'b1;
            end
            default:
                line_bad = 1'b1;
        endcase
    endfunction

    // Apply one accepted byte; a line feed that closes a good line owes a word
    function automatic void take_byte(input logic [7:0] b);
        logic        good;
        logic [63:0] total;
        logic [63:0] scale;
        reading_t    r;
        if (b == CH_CR)
            return;
        if (b != CH_LF)
        begin
            advance_parser(b);
            line_pos = line_pos + 7'd1;
            // A full line buffer wraps and starts parsing over
            if (line_pos >= LINE_LEN)
            begin
                line_pos = 7'd0;
                clear_line();
            end
            return;
        end
        good = 1'b0;
        if (!line_bad)
        begin
            if (line_gas == KIND_GAS)
                good = pstate inside {PS_GAS_INT, PS_GAS_FRAC, PS_DONE};
            else
                good = pstate inside {PS_PWR_FRAC, PS_DONE};
        end
        if (good)
        begin
            r.kind = line_gas;
            if (line_gas == KIND_POWER)
            begin
                power_readings = power_readings + 16'd1;
                scale   = meter_ver ? 64'd1 : 64'd10;
                total   = {16'd0, whole_acc} * 64'd1000 + {32'd0, frac_acc} * scale;
                r.watts = (total > {32'd0, POWER_MAX}) ? POWER_MAX : total[31:0];
                r.gas   = '0;
            end
            else
            begin
                case (frac_cnt)
                    2'd0:    scale = 64'd1000;
                    2'd1:    scale = 64'd100;
                    2'd2:    scale = 64'd10;
                    default: scale = 64'd1;
                endcase
                total   = {16'd0, whole_acc} * 64'd1000 + {32'd0, frac_acc} * scale;
                r.gas   = (total > {16'd0, GAS_MAX}) ? GAS_MAX : total[47:0];
                r.watts = '0;
            end
            r.count = power_readings;
            expected_readings.push_back(r);
        end
        line_pos = 7'd0;
        clear_line();
    endfunction

    // Track config writes and accepted bytes at the edge that takes them
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            meter_ver      = 1'b1;
            line_pos       = 7'd0;
            power_readings = 16'd0;
            clear_line();
        end
        else
        begin
            if (cfg_write)
                meter_ver = cfg_data;
            if (push && !full)
                take_byte(rx_byte);
        end
    end

    // Compare each popped word with the oldest one owed
    always @(posedge clk)
    begin : check_reading
        reading_t want;
        if (rst_n && pop && !empty)
        begin
            if (expected_readings.size() == 0)
            begin
                $error("word popped with none owed: kind %0d count %0d watts %0d gas %0d",
                       reading_kind, reading_count, power_watts, gas_thousandths);
                fail_count++;
            end
            else
            begin
                want = expected_readings.pop_front();
                if (reading_kind !== want.kind)
                begin
                    $error("reading_kind: expected %0d, got %0d", want.kind, reading_kind);
                    fail_count++;
                end
                if (reading_count !== want.count)
                begin
                    $error("reading_count: expected %0d, got %0d", want.count, reading_count);
                    fail_count++;
                end
                if (power_watts !== want.watts)
                begin
                    $error("power_watts: expected %0d, got %0d", want.watts, power_watts);
                    fail_count++;
                end
                if (gas_thousandths !== want.gas)
                begin
                    $error("gas_thousandths: expected %0d, got %0d",
                           want.gas, gas_thousandths);
                    fail_count++;
                end
            end
        end
    end

    // Receiver: stall on a rotating random mask, or
    // hold off for a long stretch on request so the line queue backs up
    initial
    begin : receiver
        int          tick;
        logic [31:0] mask;
        tick = 0;
        mask = '1;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                pop <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                if (tick % 64 == 0)
                begin
                    case ($urandom_range(0, 3))
                        0:       mask = '1;
                        1:       mask = $urandom;
                        2:       mask = $urandom & $urandom;
                        default: mask = $urandom | $urandom;
                    endcase
                    if (mask == 0)
                        mask = 32'h1;
                end
                pop <= mask[tick % 32];
                tick++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender helpers
    // ------------------------------------------------------------------

    // Offer one byte and hold it until the block takes it. Between random
    // bursts drop push for a random gap; in steady mode never gap.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (!steady && burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        if (burst_left > 0)
            burst_left--;
        push    <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    task automatic add_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            line_bytes.push_back(s.getc(i));
    endtask

    task automatic add_tag(input logic kind, input int n);
        int i;
        for (i = 0; i < n; i++)
            line_bytes.push_back(tag_at(kind, i[3:0]));
    endtask

    task automatic add_digits(input int n);
        repeat (n) line_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    task automatic add_eol();
        line_bytes.push_back(CH_CR);
        line_bytes.push_back(CH_LF);
    endtask

    task automatic send_line();
        int i;
        for (i = 0; i < line_bytes.size(); i++)
            send_byte(line_bytes[i]);
        bytes_sent += line_bytes.size();
        line_bytes.delete();
    endtask

    task automatic send_text_line(input string s);
        add_text(s);
        add_eol();
        send_line();
    endtask

    // Drop push and wait until every owed word has been popped, then let the
    // pipeline settle so nothing is still in flight
    task automatic drain_readings();
        int waited;
        push <= 1'b0;
        @(posedge clk);
        waited = 0;
        while (expected_readings.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (expected_readings.size() != 0)
        begin
            $error("%0d reading words never arrived", expected_readings.size());
            fail_count++;
            expected_readings.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write protocol_version; only called from an idle block
    task automatic set_protocol(input logic v);
        cfg_write <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    function automatic int digit_run();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(8, 22);
        return $urandom_range(1, 4);
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Power lines on the newer telegram: zero, plain value, exact and
    // overflowing 32-bit ceiling, digit saturation, and forms that fail
    task automatic test_power_readings();
        set_protocol(1'b1);
        send_text_line("1-0:1.7.0(00.000*kW)");
        send_text_line("1-0:1.7.0(01.234*kW)");
        send_text_line("1-0:1.7.0(4294967.295*kW)");
        send_text_line("1-0:1.7.0(4294967.296*kW)");
        send_text_line("1-0:1.7.0(999999999999999.9999999999)");
        send_text_line("1-0:1.7.0(12.*kW)");
        send_text_line("1-0:1.7.0(12*kW)");
        send_text_line("1-0:1.7.0(.5*kW)");
        drain_readings();
    endtask

    // Gas forms: whole only, trailing dot, short fraction, leading dot, dot
    // alone, truncated fraction, timestamp first, whole-part saturation
    task automatic test_gas_readings();
        send_text_line("0-1:24.2.1(5)");
        send_text_line("0-1:24.2.1(5.)");
        send_text_line("0-1:24.2.1(5.25*m3)");
        send_text_line("0-1:24.2.1(.5)");
        send_text_line("0-1:24.2.1(.)");
        send_text_line("0-1:24.2.1(12785.12345*m3)");
        send_text_line("0-1:24.2.1(101209112500W)(12785.123*m3)");
        send_text_line("0-1:24.2.1(9999999999999999.999)");
        drain_readings();
    endtask

    // Carriage return inside a line, NUL bytes, sign, whitespace, exponent,
    // wrong prefixes and empty lines
    task automatic test_line_edge_cases();
        add_text("1-0:1.7");
        line_bytes.push_back(CH_CR);
        add_text(".0(1.5");
        add_eol();
        send_line();
        add_text("1-0:1.7.0(1.5");
        line_bytes.push_back(CH_NUL);
        add_text("7*kW)");
        add_eol();
        send_line();
        add_text("1-0:1");
        line_bytes.push_back(CH_NUL);
        add_text(".7.0(1.5");
        add_eol();
        send_line();
        send_text_line("1-0:1.7.0(-1.5*kW)");
        send_text_line("0-1:24.2.1(+5)");
        send_text_line("0-1:24.2.1( 5)");
        send_text_line("0-1:24.2.1(5 7)");
        send_text_line("0-1:24.2.1(5e3)");
        send_text_line("1-0:2.7.0(1.5*kW)");
        send_text_line("0-0:24.2.1(5)");
        send_text_line("");
        line_bytes.push_back(CH_LF);
        send_line();
        drain_readings();
    endtask

    // Lines around the buffer length: one byte short still matches, a full
    // buffer wraps and drops the line, and parsing resumes after the wrap
    task automatic test_long_lines();
        add_text("1-0:1.7.0(2.5");
        while (line_bytes.size() < LINE_LEN - 1)
            line_bytes.push_back("x");
        add_eol();
        send_line();
        add_text("1-0:1.7.0(2.5");
        while (line_bytes.size() < LINE_LEN)
            line_bytes.push_back("x");
        send_text_line("1-0:1.7.0(3.25*kW)");
        drain_readings();
    endtask

    // Older telegram scales the power fraction by ten; gas is unaffected
    task automatic test_protocol_versions();
        set_protocol(1'b0);
        send_text_line("1-0:1.7.0(01.23*kW)");
        send_text_line("1-0:1.7.0(429496.7295*kW)");
        send_text_line("1-0:1.7.0(4294967.30*kW)");
        send_text_line("0-1:24.2.1(1.5*m3)");
        drain_readings();
        set_protocol(1'b1);
        send_text_line("1-0:1.7.0(01.23*kW)");
        drain_readings();
        set_protocol(1'b0);
        send_text_line("1-0:1.7.0(00.01*kW)");
        drain_readings();
    endtask

    // Hold the receiver off while the sender streams short power lines back
    // to back, so the queue fills and full stalls the input
    task automatic test_queue_full();
        hold_req = 1'b1;
        steady   = 1'b1;
        repeat (8)
        begin
            add_tag(KIND_POWER, int'(POWER_TAG_LEN));
            add_digits($urandom_range(1, 3));
            line_bytes.push_back(CH_DOT);
            add_digits($urandom_range(1, 3));
            line_bytes.push_back(CH_LF);
            send_line();
        end
        steady = 1'b0;
        drain_readings();
    endtask

    // Build one random line: mostly well-formed readings with random digits,
    // some damaged, plus noise, cut prefixes, overlong and empty lines
    task automatic build_random_line();
        int  pick;
        int  n;
        bit  kind;
        pick = $urandom_range(0, 99);
        if (pick < 36)
        begin
            add_tag(KIND_POWER, int'(POWER_TAG_LEN));
            add_digits(digit_run());
            line_bytes.push_back(CH_DOT);
            add_digits(digit_run());
            if ($urandom_range(0, 1))
                add_text("*kW)");
        end
        else if (pick < 70)
        begin
            add_tag(KIND_GAS, int'(GAS_TAG_LEN));
            case ($urandom_range(0, 3))
                0:
                    add_digits(digit_run());
                1:
                begin
                    add_digits(digit_run());
                    line_bytes.push_back(CH_DOT);
                end
                2:
                begin
                    add_digits(digit_run());
                    line_bytes.push_back(CH_DOT);
                    add_digits($urandom_range(1, 5));
                end
                default:
                begin
                    line_bytes.push_back(CH_DOT);
                    add_digits($urandom_range(1, 5));
                end
            endcase
            if ($urandom_range(0, 1))
                add_text("*m3)");
        end
        else if (pick < 82)
        begin
            n = $urandom_range(1, 30);
            repeat (n) line_bytes.push_back(8'($urandom_range(0, 255)));
        end
        else if (pick < 86)
        begin
            n = $urandom_range(LINE_LEN - 10, LINE_LEN + 20);
            repeat (n) line_bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
            add_tag(KIND_POWER, int'(POWER_TAG_LEN));
            add_text("1.5");
        end
        else if (pick < 94)
        begin
            // Cut the prefix short and follow it with an arbitrary byte
            kind = 1'($urandom_range(0, 1));
            add_tag(kind, $urandom_range(0, (kind == KIND_GAS) ? 10 : 9));
            line_bytes.push_back(8'($urandom_range(0, 255)));
        end
        // Damage a few good readings: overwrite one byte, often with a CR
        if (pick < 70 && $urandom_range(0, 9) == 0)
            line_bytes[$urandom_range(0, line_bytes.size() - 1)] =
                ($urandom_range(0, 2) == 0) ? CH_CR : 8'($urandom_range(0, 255));
        if ($urandom_range(0, 3) != 0)
            line_bytes.push_back(CH_CR);
        line_bytes.push_back(CH_LF);
    endtask

    // Random telegrams; set a random protocol version between groups of lines
    task automatic test_random_telegrams();
        int first_byte;
        int lines;
        first_byte = bytes_sent;
        lines = 0;
        while (bytes_sent - first_byte < RANDOM_BYTES)
        begin
            build_random_line();
            send_line();
            lines++;
            if (lines % 4 == 0)
            begin
                drain_readings();
                set_protocol(1'($urandom_range(0, 1)));
            end
        end
        drain_readings();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin : run
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_power_readings();
        test_gas_readings();
        test_line_edge_cases();
        test_long_lines();
        test_protocol_versions();
        test_queue_full();
        test_random_telegrams();
        if (fail_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
